[sv/mfr_pkg.sv]
// Package for the motor frame relay: constants, byte codes, state type and CRC-8 step.
// Used by motor_frame_relay_crc8. Depends on nothing.
`default_nettype none

package mfr_pkg;

    // Default geometry of a frame and of the motor set.
    localparam int MOTOR_COUNT_DEF  = 8;
    localparam int FRAME_LENGTH_DEF = 11;

    // Frame position counter width; enough for the longest frame.
    localparam int POS_W = 4;

    // Framing and protocol bytes.
    localparam logic [7:0] CRC_XOR    = 8'hD5;
    localparam logic [7:0] START_BYTE = 8'h12;
    localparam logic [7:0] END_BYTE   = 8'h13;
    localparam logic [7:0] CMD_MOTOR  = 8'h01;
    localparam logic [7:0] CMD_POLL   = 8'h03;
    localparam logic [7:0] DIR_LIMIT  = 8'd128;
    localparam logic [7:0] MAG_TRAP   = 8'd18;
    localparam logic [7:0] MAG_SUB    = 8'd17;

    // Poll address sequence and interval reset value.
    localparam logic [3:0] POLL_FIRST        = 4'd1;
    localparam logic [3:0] POLL_WRAP         = 4'd9;
    localparam logic [7:0] POLL_INTERVAL_RST = 8'd20;

    // Byte slots of an outgoing 7-byte packet.
    typedef enum logic [2:0] {
        B_START,
        B_ADDR,
        B_CMD,
        B_ARG0,
        B_ARG1,
        B_CRC,
        B_END
    } t_byte_sel;

    // Control states of the relay.
    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_EMIT,
        ST_DRAIN
    } t_state;

    // One byte of the reflected CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ CRC_XOR;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/mfr_if.sv]
// Handshake channel interfaces of the motor frame relay: received bytes, sent bytes, config.
// Stand-alone; used by motor_frame_relay_crc8.
`default_nettype none

// Received byte channel.
interface mfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Transmitted byte channel; last marks the final beat of a burst.
interface mfr_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output tx_byte, output last, input ready);
    modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

// Configuration write channel for the poll interval register.
interface mfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] poll_interval;

    modport source (output valid, output poll_interval, input ready);
    modport sink   (input valid, input poll_interval, output ready);
endinterface

`default_nettype wire

[sv/motor_frame_relay_crc8.sv]
// Motor frame relay: checks CRC-8 framed motor commands and relays them as motor packets.
// Depends on mfr_pkg and the channel interfaces in mfr_if.sv.
`default_nettype none

//  Channel  | Dir | Payload                  | Beat
//  i_rx     | in  | rx_byte[7:0]             | one received byte
//  o_tx     | out | tx_byte[7:0], last       | one byte for the motor link
//  i_cfg    | in  | poll_interval[7:0]       | one register write
//
//  A received byte that completes no valid frame starts no burst, and i_rx stays ready.
//  A valid frame sends MOTOR_COUNT packets plus an optional poll packet; each packet
//  passes through one read state (ST_READ) and seven output beats, so a full burst
//  of the default eight motors plus a poll packet is 63 bytes.
//  i_rx is held off until the last beat of a burst is taken; o_tx stalls just pause it.
//  Reset is synchronous, active low; the motor memory needs no clearing.

module motor_frame_relay_crc8 #(
    parameter int MOTOR_COUNT  = mfr_pkg::MOTOR_COUNT_DEF,
    parameter int FRAME_LENGTH = mfr_pkg::FRAME_LENGTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mfr_rx_if.sink      i_rx,
    mfr_tx_if.source    o_tx,
    mfr_cfg_if.sink     i_cfg
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int PKT_W = $clog2(MOTOR_COUNT + 1);
    localparam int POS_W = mfr_pkg::POS_W;

    localparam logic [POS_W-1:0] POS_LAST_MOTOR = POS_W'(FRAME_LENGTH - 3);
    localparam logic [POS_W-1:0] POS_CRC        = POS_W'(FRAME_LENGTH - 2);
    localparam logic [PKT_W-1:0] PKT_POLL       = PKT_W'(MOTOR_COUNT);
    localparam logic [PKT_W-1:0] PKT_LAST_MOTOR = PKT_W'(MOTOR_COUNT - 1);

    // Motor value memory, one synchronous read port and one write port.
    logic [7:0] r_mem [MOTOR_COUNT];
    logic [7:0] r_mem_q;

    mfr_pkg::t_state    r_state;
    mfr_pkg::t_state    n_state;
    mfr_pkg::t_byte_sel r_bidx;
    mfr_pkg::t_byte_sel n_bidx;

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic [7:0]       r_fsp;
    logic [3:0]       r_poll_target;
    logic [7:0]       r_poll_interval;
    logic             r_poll_en;
    logic [PKT_W-1:0] r_pkt;
    logic [7:0]       r_pkt_crc;
    logic             r_tx_valid;
    logic [7:0]       r_tx_byte;
    logic             r_tx_last;

    logic             rx_ready;
    logic             rx_acc;
    logic             load;
    logic             rd_en;
    logic             is_start;
    logic             is_motor_pos;
    logic             is_crc_pos;
    logic             frame_ok;
    logic             mem_we;
    logic [POS_W-1:0] motor_idx;
    logic [7:0]       fsp_inc;
    logic             poll_now;
    logic             is_poll;
    logic             last_pkt;
    logic [7:0]       arg_addr;
    logic [7:0]       arg_cmd;
    logic [7:0]       arg0;
    logic [7:0]       arg1;
    logic [7:0]       mag;
    logic [7:0]       cur_byte;

    // Receive-side decode of the current byte.
    always_comb begin
        rx_acc       = i_rx.valid && rx_ready;
        is_start     = (i_rx.rx_byte == mfr_pkg::START_BYTE);
        is_motor_pos = (r_pos != '0) && (r_pos <= POS_LAST_MOTOR);
        is_crc_pos   = (r_pos == POS_CRC);
        motor_idx    = r_pos - POS_W'(1);
        mem_we       = rx_acc && !is_start && is_motor_pos
                       && (motor_idx < POS_W'(MOTOR_COUNT));
        frame_ok     = rx_acc && !is_start && (r_pos != '0) && !is_motor_pos
                       && !is_crc_pos && (i_rx.rx_byte == mfr_pkg::END_BYTE)
                       && (r_crc == 8'd0);
        fsp_inc      = r_fsp + 8'd1;
        poll_now     = (fsp_inc > r_poll_interval);
    end

    // Contents of the next outgoing byte.
    always_comb begin
        is_poll  = (r_pkt == PKT_POLL);
        last_pkt = is_poll || ((r_pkt == PKT_LAST_MOTOR) && !r_poll_en);
        mag      = {r_mem_q[6:0], 1'b0};
        if (mag == mfr_pkg::MAG_TRAP) begin
            mag = mfr_pkg::MAG_SUB;
        end
        arg_addr = is_poll ? {4'd0, r_poll_target} : (8'(r_pkt) + 8'd1);
        arg_cmd  = is_poll ? mfr_pkg::CMD_POLL : mfr_pkg::CMD_MOTOR;
        arg0     = is_poll ? 8'd0 : ((r_mem_q < mfr_pkg::DIR_LIMIT) ? 8'd1 : 8'd0);
        arg1     = is_poll ? 8'd0 : mag;
        case (r_bidx)
            mfr_pkg::B_START: begin
                cur_byte = mfr_pkg::START_BYTE;
                n_bidx   = mfr_pkg::B_ADDR;
            end
            mfr_pkg::B_ADDR: begin
                cur_byte = arg_addr;
                n_bidx   = mfr_pkg::B_CMD;
            end
            mfr_pkg::B_CMD: begin
                cur_byte = arg_cmd;
                n_bidx   = mfr_pkg::B_ARG0;
            end
            mfr_pkg::B_ARG0: begin
                cur_byte = arg0;
                n_bidx   = mfr_pkg::B_ARG1;
            end
            mfr_pkg::B_ARG1: begin
                cur_byte = arg1;
                n_bidx   = mfr_pkg::B_CRC;
            end
            mfr_pkg::B_CRC: begin
                cur_byte = r_pkt_crc;
                n_bidx   = mfr_pkg::B_END;
            end
            mfr_pkg::B_END: begin
                cur_byte = mfr_pkg::END_BYTE;
                n_bidx   = mfr_pkg::B_START;
            end
            default: begin
                cur_byte = mfr_pkg::END_BYTE;
                n_bidx   = mfr_pkg::B_START;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfr_pkg::ST_RECV: begin
                if (frame_ok) begin
                    n_state = mfr_pkg::ST_READ;
                end
            end
            mfr_pkg::ST_READ: begin
                n_state = mfr_pkg::ST_EMIT;
            end
            mfr_pkg::ST_EMIT: begin
                if (load && (r_bidx == mfr_pkg::B_END)) begin
                    n_state = last_pkt ? mfr_pkg::ST_DRAIN : mfr_pkg::ST_READ;
                end
            end
            mfr_pkg::ST_DRAIN: begin
                if (o_tx.ready) begin
                    n_state = mfr_pkg::ST_RECV;
                end
            end
            default: begin
                n_state = mfr_pkg::ST_RECV;
            end
        endcase
    end

    // State outputs: input handshake, output load and memory read enable.
    always_comb begin
        rx_ready = 1'b0;
        load     = 1'b0;
        rd_en    = 1'b0;
        case (r_state)
            mfr_pkg::ST_RECV: begin
                rx_ready = i_rst_n;
            end
            mfr_pkg::ST_READ: begin
                rd_en = (r_pkt < PKT_POLL);
            end
            mfr_pkg::ST_EMIT: begin
                load = !r_tx_valid || o_tx.ready;
            end
            default: begin
                rx_ready = 1'b0;
            end
        endcase
    end

    // Neither input channel takes a beat while reset is held.
    assign i_rx.ready      = rx_ready;
    assign i_cfg.ready     = i_rst_n;
    assign o_tx.valid      = r_tx_valid;
    assign o_tx.tx_byte    = r_tx_byte;
    assign o_tx.last       = r_tx_last;

    // Motor memory: writes happen only while receiving and reads only while sending,
    // so the two ports never touch the same entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[motor_idx[IDX_W-1:0]] <= i_rx.rx_byte;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_pkt[IDX_W-1:0]];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= mfr_pkg::ST_RECV;
            r_bidx          <= mfr_pkg::B_START;
            r_pos           <= '0;
            r_crc           <= 8'd0;
            r_fsp           <= 8'd0;
            r_poll_target   <= mfr_pkg::POLL_FIRST;
            r_poll_interval <= mfr_pkg::POLL_INTERVAL_RST;
            r_poll_en       <= 1'b0;
            r_pkt           <= '0;
            r_tx_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                r_poll_interval <= i_cfg.poll_interval;
            end

            // Frame hunting and collection; a start byte always restarts the frame.
            if (rx_acc) begin
                if (is_start) begin
                    r_pos <= POS_W'(1);
                    r_crc <= 8'd0;
                end else if (r_pos == '0) begin
                    r_pos <= '0;
                end else if (is_motor_pos) begin
                    r_crc <= mfr_pkg::crc8_byte(r_crc, i_rx.rx_byte);
                    r_pos <= r_pos + POS_W'(1);
                end else if (is_crc_pos) begin
                    r_crc <= r_crc ^ i_rx.rx_byte;
                    r_pos <= r_pos + POS_W'(1);
                end else begin
                    r_pos <= '0;
                end
            end

            // A good frame starts a burst and counts toward the next poll.
            if (frame_ok) begin
                r_pkt     <= '0;
                r_bidx    <= mfr_pkg::B_START;
                r_poll_en <= poll_now;
                r_fsp     <= poll_now ? 8'd0 : fsp_inc;
            end

            // Output register: take a beat away, or load the next one.
            if (load) begin
                r_tx_valid <= 1'b1;
                r_bidx     <= n_bidx;
                if (r_bidx == mfr_pkg::B_END) begin
                    r_pkt <= r_pkt + PKT_W'(1);
                    if (is_poll) begin
                        if (r_poll_target + 4'd1 == mfr_pkg::POLL_WRAP) begin
                            r_poll_target <= mfr_pkg::POLL_FIRST;
                        end else begin
                            r_poll_target <= r_poll_target + 4'd1;
                        end
                    end
                end
            end else if (r_tx_valid && o_tx.ready) begin
                r_tx_valid <= 1'b0;
            end
        end
    end

    // Output payload and the running packet CRC over address through second argument.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_byte <= cur_byte;
            r_tx_last <= (r_bidx == mfr_pkg::B_END) && last_pkt;
            if (r_bidx == mfr_pkg::B_START) begin
                r_pkt_crc <= 8'd0;
            end else if ((r_bidx == mfr_pkg::B_ADDR) || (r_bidx == mfr_pkg::B_CMD)
                         || (r_bidx == mfr_pkg::B_ARG0) || (r_bidx == mfr_pkg::B_ARG1)) begin
                r_pkt_crc <= mfr_pkg::crc8_byte(r_pkt_crc, cur_byte);
            end
        end
    end

endmodule

`default_nettype wire
